>>> src/b64d_pkg.sv
package b64d_pkg;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       bad_char;
      logic       message_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_BLANK,
      CLS_PAD,
      CLS_DATA,
      CLS_BAD
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [5:0] value;
      logic       last;
   } tok_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DIG_0 = 8'h30;
   localparam logic [7:0] CHAR_DIG_9 = 8'h39;

   function automatic tok_type classify(input req_type r);
      tok_type    t;
      logic [7:0] c;
      c       = r.char_in;
      t.last  = r.end_of_message;
      t.value = 6'd0;
      t.cls   = CLS_BAD;
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
         t.cls = CLS_BLANK;
      end else if (c == CHAR_PAD) begin
         t.cls = CLS_PAD;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         t.cls   = CLS_DATA;
         t.value = 6'(c - CHAR_UC_A);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         t.cls   = CLS_DATA;
         t.value = 6'(c - CHAR_LC_A + 8'd26);
      end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
         t.cls   = CLS_DATA;
         t.value = 6'(c - CHAR_DIG_0 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         t.cls   = CLS_DATA;
         t.value = 6'd62;
      end else if (c == CHAR_SLASH) begin
         t.cls   = CLS_DATA;
         t.value = 6'd63;
      end
      return t;
   endfunction

endpackage

>>> src/b64d_front.sv
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req,
   output logic              tok_valid,
   input  logic              tok_stall,
   output b64d_pkg::tok_type tok
);

   logic              valid_ff, valid_in;
   b64d_pkg::tok_type tok_ff;
   logic              take;

   assign req_stall = valid_ff && tok_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!tok_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff <= b64d_pkg::classify(req);
      end
   end

   assign tok_valid = valid_ff;
   assign tok       = tok_ff;

endmodule

>>> src/b64d_queue.sv
module b64d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  b64d_pkg::tok_type in_tok,
   output logic              out_valid,
   input  logic              out_stall,
   output b64d_pkg::tok_type out_tok
);

   b64d_pkg::tok_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_tok   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_tok;
      end
   end

endmodule

>>> src/b64d_back.sv
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   output logic              tok_stall,
   input  b64d_pkg::tok_type tok,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp
);

   logic [5:0]        store_ff, store_in;
   logic [1:0]        pairs_ff, pairs_in;
   logic              pad_ff, pad_in;
   logic              err_ff, err_in;
   logic              valid_ff, valid_in;
   b64d_pkg::rsp_type rsp_ff, rsp_in;
   logic              pop, emit;

   assign tok_stall = valid_ff && rsp_stall;
   assign pop       = tok_valid && !tok_stall;

   always_comb begin
      store_in = store_ff;
      pairs_in = pairs_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;
      rsp_in   = '0;
      if (!pad_ff && !err_ff) begin
         unique case (tok.cls)
            b64d_pkg::CLS_BLANK: begin
            end
            b64d_pkg::CLS_PAD: begin
               pad_in = 1'b1;
            end
            b64d_pkg::CLS_BAD: begin
               err_in          = 1'b1;
               rsp_in.bad_char = 1'b1;
            end
            b64d_pkg::CLS_DATA: begin
               unique case (pairs_ff)
                  2'd0: begin
                     store_in = tok.value;
                     pairs_in = 2'd3;
                  end
                  2'd1: begin
                     rsp_in.byte_out   = {store_ff[1:0], tok.value};
                     rsp_in.byte_valid = 1'b1;
                     store_in          = 6'd0;
                     pairs_in          = 2'd0;
                  end
                  2'd2: begin
                     rsp_in.byte_out   = {store_ff[3:0], tok.value[5:2]};
                     rsp_in.byte_valid = 1'b1;
                     store_in          = {4'd0, tok.value[1:0]};
                     pairs_in          = 2'd1;
                  end
                  2'd3: begin
                     rsp_in.byte_out   = {store_ff, tok.value[5:4]};
                     rsp_in.byte_valid = 1'b1;
                     store_in          = {2'd0, tok.value[3:0]};
                     pairs_in          = 2'd2;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      rsp_in.message_done = tok.last;
      emit = rsp_in.byte_valid || rsp_in.bad_char || tok.last;
      // message boundary clears everything for the next message
      if (tok.last) begin
         store_in = 6'd0;
         pairs_in = 2'd0;
         pad_in   = 1'b0;
         err_in   = 1'b0;
      end
      valid_in = valid_ff && rsp_stall;
      if (pop && emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= 6'd0;
         pairs_ff <= 2'd0;
         pad_ff   <= 1'b0;
         err_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            store_ff <= store_in;
            pairs_ff <= pairs_in;
            pad_ff   <= pad_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/base64_stream_decoder.sv
// channel | ports                        | word
// input   | req_valid, req_stall, req    | one character and its end-of-message flag
// result  | rsp_valid, rsp_stall, rsp    | one decoded byte, error flag or end mark
//
// one character accepted per cycle while req_stall is low
// path: classify register, two-entry queue, decode state and result register
// reset (synchronous) empties all stages and clears the decode state
// a stall on the result side backs up the queue before it reaches the input
module base64_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp
);

   logic              f_valid, f_stall;
   b64d_pkg::tok_type f_tok;
   logic              q_valid, q_stall;
   b64d_pkg::tok_type q_tok;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .tok_valid (f_valid),
      .tok_stall (f_stall),
      .tok       (f_tok)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_tok    (f_tok),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_tok   (q_tok)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok_stall (q_stall),
      .tok       (q_tok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

>>> src/b64d_checker.sv
module b64d_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input b64d_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input b64d_pkg::rsp_type rsp
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req))
      else $error("request word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result word changed while stalled");

   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.byte_valid || rsp.bad_char || rsp.message_done))
      else $error("empty result word");

   a_byte_or_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp.byte_valid && rsp.bad_char))
      else $error("byte and error in one word");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.byte_valid |-> rsp.byte_out == 8'd0)
      else $error("byte field not zero without a byte");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
